// ===== src/lcm_pkg.sv =====
`default_nettype none
package lcm_pkg;

  localparam int LEN_W = 6;
  localparam int SMP_W = 16;
  localparam int PROD_W = 32;
  // 32 products of Q2.30 magnitude at most 2^30 each
  localparam int ACC_W = 37;
  localparam int VAL_W = 24;
  localparam int POS_W = 6;
  localparam int CFG_AW = 2;
  localparam int FRAC_SHIFT = 15;

  localparam logic [1:0] ACT_LOAD_SIG = 2'd0;
  localparam logic [1:0] ACT_LOAD_KER = 2'd1;
  localparam logic [1:0] ACT_RUN      = 2'd2;

  localparam logic [1:0] CROP_FULL  = 2'd0;
  localparam logic [1:0] CROP_SAME  = 2'd1;
  localparam logic [1:0] CROP_VALID = 2'd2;

  localparam logic [CFG_AW-1:0] REG_SIG_LEN = 2'd0;
  localparam logic [CFG_AW-1:0] REG_KER_LEN = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CROP    = 2'd2;

  typedef struct packed {
    logic [1:0]             action;
    logic signed [SMP_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    last;
    logic                    status;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] sig_len;
    logic [LEN_W-1:0] ker_len;
    logic [1:0]       crop;
  } cfg_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ISSUE,
    ST_DRAIN,
    ST_PUSH
  } state_t;

endpackage
`default_nettype wire

// ===== src/lcm_store.sv =====
`default_nettype none
module lcm_store
  import lcm_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic signed [SMP_W-1:0] wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic signed [SMP_W-1:0]      rdata
);

  logic signed [SMP_W-1:0] mem [DEPTH];
  logic signed [SMP_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/lcm_mac.sv =====
`default_nettype none
module lcm_mac
  import lcm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mac_ctl_t                ctl,
  input  wire logic signed [SMP_W-1:0] sig_q,
  input  wire logic signed [SMP_W-1:0] ker_q,
  output logic                         done,
  output logic signed [VAL_W-1:0]      value
);

  // stage 1 lines up with the memory read data, stage 2 with the product
  logic v1_r, f1_r, l1_r;
  logic v2_r, f2_r, l2_r;
  logic done_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      f1_r   <= 1'b0;
      l1_r   <= 1'b0;
      v2_r   <= 1'b0;
      f2_r   <= 1'b0;
      l2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= ctl.issue;
      f1_r   <= ctl.first;
      l1_r   <= ctl.last;
      v2_r   <= v1_r;
      f2_r   <= f1_r;
      l2_r   <= l1_r;
      done_r <= v2_r & l2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= sig_q * ker_q;
    end
    if (v2_r) begin
      if (f2_r) begin
        acc_r <= ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  // round half up: add half an lsb, then floor shift
  assign rnd     = acc_r + ACC_W'(1 <<< (FRAC_SHIFT - 1));
  assign shifted = rnd >>> FRAC_SHIFT;
  assign value   = shifted[VAL_W-1:0];
  assign done    = done_r;

endmodule
`default_nettype wire

// ===== src/lcm_ctrl.sv =====
`default_nettype none
module lcm_ctrl
  import lcm_pkg::*;
#(
  parameter int MAX_SIGNAL = 32,
  parameter int MAX_KERNEL = 32,
  parameter int SAW = 5,
  parameter int KAW = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [1:0]              in_action,
  output logic                         in_stall,
  input  wire cfg_t                    cfg,
  output logic [SAW-1:0]               sig_raddr,
  output logic [KAW-1:0]               ker_raddr,
  output mac_ctl_t                     mac_ctl,
  input  wire logic                    mac_done,
  input  wire logic signed [VAL_W-1:0] mac_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output out_item_t                    out_data
);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0] n_r, n_nxt, m_r, m_nxt;
  logic [LEN_W-1:0] k_r, k_nxt, i_r, i_nxt, count_r, count_nxt;
  logic [SAW-1:0]   j_r, j_nxt, jhi_r, jhi_nxt;
  logic             err_r, err_nxt, first_r, first_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r, out_item;
  logic             out_load;

  logic [LEN_W-1:0] n_c, m_c, m1, n1, jlo, jhi;
  logic [LEN_W:0]   kdiff;
  logic             run_req, final_item;

  always_comb begin
    if (cfg.sig_len == '0) begin
      n_c = LEN_W'(1);
    end else if (cfg.sig_len > LEN_W'(MAX_SIGNAL)) begin
      n_c = LEN_W'(MAX_SIGNAL);
    end else begin
      n_c = cfg.sig_len;
    end
    if (cfg.ker_len == '0) begin
      m_c = LEN_W'(1);
    end else if (cfg.ker_len > LEN_W'(MAX_KERNEL)) begin
      m_c = LEN_W'(MAX_KERNEL);
    end else begin
      m_c = cfg.ker_len;
    end
  end

  assign run_req    = in_valid && (in_action == ACT_RUN);
  assign final_item = err_r || (i_r == count_r - LEN_W'(1));
  assign out_load   = (state_r == ST_PUSH) && (!out_valid_r || !out_stall);

  // span of signal indices that meet a kernel tap for output k
  assign m1  = m_r - LEN_W'(1);
  assign n1  = n_r - LEN_W'(1);
  assign jlo = (k_r >= m1) ? (k_r - m1) : '0;
  assign jhi = (k_r < n1) ? k_r : n1;
  assign kdiff = {1'b0, k_r} - (LEN_W + 1)'(j_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (run_req) begin
          if ((cfg.crop == CROP_VALID) && (m_c > n_c)) begin
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: state_nxt = ST_ISSUE;
      ST_ISSUE: begin
        if (j_r == jhi_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          state_nxt = final_item ? ST_IDLE : ST_START;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_stall  = 1'b1;
    mac_ctl   = '0;
    sig_raddr = j_r;
    ker_raddr = kdiff[KAW-1:0];
    n_nxt     = n_r;
    m_nxt     = m_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    count_nxt = count_r;
    j_nxt     = j_r;
    jhi_nxt   = jhi_r;
    err_nxt   = err_r;
    first_nxt = first_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (run_req) begin
          n_nxt   = n_c;
          m_nxt   = m_c;
          i_nxt   = '0;
          err_nxt = 1'b0;
          unique case (cfg.crop)
            CROP_SAME: begin
              k_nxt     = (m_c - LEN_W'(1)) >> 1;
              count_nxt = n_c;
            end
            CROP_VALID: begin
              err_nxt   = (m_c > n_c);
              k_nxt     = m_c - LEN_W'(1);
              count_nxt = n_c - m_c + LEN_W'(1);
            end
            default: begin
              k_nxt     = '0;
              count_nxt = n_c + m_c - LEN_W'(1);
            end
          endcase
        end
      end
      ST_START: begin
        j_nxt     = jlo[SAW-1:0];
        jhi_nxt   = jhi[SAW-1:0];
        first_nxt = 1'b1;
      end
      ST_ISSUE: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.first = first_r;
        mac_ctl.last  = (j_r == jhi_r);
        j_nxt         = j_r + SAW'(1);
        first_nxt     = 1'b0;
      end
      ST_DRAIN: begin
      end
      ST_PUSH: begin
        if (out_load && !final_item) begin
          k_nxt = k_r + LEN_W'(1);
          i_nxt = i_r + LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_item.value    = err_r ? '0 : mac_value;
    out_item.position = err_r ? '0 : i_r;
    out_item.last     = final_item;
    out_item.status   = err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    m_r     <= m_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    count_r <= count_nxt;
    j_r     <= j_nxt;
    jhi_r   <= jhi_nxt;
    err_r   <= err_nxt;
    first_r <= first_nxt;
    if (out_load) begin
      out_data_r <= out_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== src/linear_convolution_modes.sv =====
// Direct 1-D linear convolution of a loaded signal with a loaded kernel.
// Input channel (in_valid / in_stall / in_data): action 0 appends a Q1.15
// signal sample, action 1 appends a kernel tap, action 2 runs the convolution;
// loads beyond the store depth are dropped, action 3 does nothing.
// Configuration (cfg_we / cfg_addr / cfg_wdata): 0 signal length, 1 kernel
// length, 2 crop mode (full, same, valid); write only while idle.
// Result channel (out_valid / out_stall / out_data): one Q9.15 sample per
// cropped output position, last set on the final one; valid mode with a
// kernel longer than the signal gives one result with status set.
// Loads are taken while idle. For each emitted sample a run takes a setup step,
// issues the overlapping taps one after another (up to 32), then waits for read,
// multiply and accumulate; the single shared multiplier is fed by the two store
// read ports, and no load is taken while a run is in progress.
// Results sit in an output register; while it is full and out_stall is high,
// it holds its result and the run waits. Reset clears the fill counters and
// restores lengths of 32 and full mode; store contents are undefined until
// loaded. A run resets both fill counters but keeps the stored data.
`default_nettype none
module linear_convolution_modes
  import lcm_pkg::*;
#(
  parameter int MAX_SIGNAL = 32,
  parameter int MAX_KERNEL = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [LEN_W-1:0]  cfg_wdata
);

  localparam int SAW = (MAX_SIGNAL > 1) ? $clog2(MAX_SIGNAL) : 1;
  localparam int KAW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int SFW = $clog2(MAX_SIGNAL + 1);
  localparam int KFW = $clog2(MAX_KERNEL + 1);

  cfg_t              cfg_r;
  logic [SFW-1:0]    sig_fill_r;
  logic [KFW-1:0]    ker_fill_r;
  logic              in_acc, sig_we, ker_we, run_acc;
  logic [SAW-1:0]    sig_raddr;
  logic [KAW-1:0]    ker_raddr;
  logic signed [SMP_W-1:0] sig_q, ker_q;
  mac_ctl_t          mac_ctl;
  logic              mac_done;
  logic signed [VAL_W-1:0] mac_value;

  assign in_acc  = in_valid && !in_stall;
  assign sig_we  = in_acc && (in_data.action == ACT_LOAD_SIG) &&
                   (sig_fill_r < SFW'(MAX_SIGNAL));
  assign ker_we  = in_acc && (in_data.action == ACT_LOAD_KER) &&
                   (ker_fill_r < KFW'(MAX_KERNEL));
  assign run_acc = in_acc && (in_data.action == ACT_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sig_len <= LEN_W'(32);
      cfg_r.ker_len <= LEN_W'(32);
      cfg_r.crop    <= CROP_FULL;
      sig_fill_r    <= '0;
      ker_fill_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SIG_LEN: cfg_r.sig_len <= cfg_wdata;
          REG_KER_LEN: cfg_r.ker_len <= cfg_wdata;
          REG_CROP:    cfg_r.crop    <= cfg_wdata[1:0];
          default: begin
          end
        endcase
      end
      if (run_acc) begin
        sig_fill_r <= '0;
        ker_fill_r <= '0;
      end else begin
        if (sig_we) begin
          sig_fill_r <= sig_fill_r + SFW'(1);
        end
        if (ker_we) begin
          ker_fill_r <= ker_fill_r + KFW'(1);
        end
      end
    end
  end

  lcm_store #(
    .DEPTH(MAX_SIGNAL),
    .AW   (SAW)
  ) u_sig_store (
    .clk  (clk),
    .we   (sig_we),
    .waddr(sig_fill_r[SAW-1:0]),
    .wdata(in_data.sample),
    .raddr(sig_raddr),
    .rdata(sig_q)
  );

  lcm_store #(
    .DEPTH(MAX_KERNEL),
    .AW   (KAW)
  ) u_ker_store (
    .clk  (clk),
    .we   (ker_we),
    .waddr(ker_fill_r[KAW-1:0]),
    .wdata(in_data.sample),
    .raddr(ker_raddr),
    .rdata(ker_q)
  );

  lcm_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .sig_q(sig_q),
    .ker_q(ker_q),
    .done (mac_done),
    .value(mac_value)
  );

  lcm_ctrl #(
    .MAX_SIGNAL(MAX_SIGNAL),
    .MAX_KERNEL(MAX_KERNEL),
    .SAW       (SAW),
    .KAW       (KAW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_data.action),
    .in_stall (in_stall),
    .cfg      (cfg_r),
    .sig_raddr(sig_raddr),
    .ker_raddr(ker_raddr),
    .mac_ctl  (mac_ctl),
    .mac_done (mac_done),
    .mac_value(mac_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
